### src/assert_macros.svh
// Assertion helpers shared by the RTL. With SYNTH defined they expand to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Checks a property on every rising clock edge outside of reset.
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Checks a condition that must hold on every rising clock edge outside of reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
    `ASSERT_PROP(lbl, clk, rstn, cond, msg)

`else

`define ASSERT_PROP(lbl, clk, rstn, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, rstn, cond, msg)

`endif

`endif

### src/jac_pkg.sv
`default_nettype none

package jac_pkg;

    // Fixed field widths of the channels.
    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned MOD_W    = 32;
    localparam int unsigned SYMBOL_W = 2;

    // Default internal operand width.
    localparam int unsigned WIDTH_DEFAULT = 32;

    // Reset value of the modulus register.
    localparam int unsigned MODULUS_RESET = 3;

    // Symbol codes.
    localparam logic signed [SYMBOL_W-1:0] SYM_ZERO = 2'sb00;
    localparam logic signed [SYMBOL_W-1:0] SYM_POS  = 2'sb01;
    localparam logic signed [SYMBOL_W-1:0] SYM_NEG  = 2'sb11;

    // Step counter of the sequencer.
    localparam int unsigned STEP_W = 4;
    typedef logic [STEP_W-1:0] step_t;

    localparam step_t STEP_IDLE     = 4'd0;
    localparam step_t STEP_CHECK    = 4'd1;
    localparam step_t STEP_MOD_INIT = 4'd2;
    localparam step_t STEP_MOD_STEP = 4'd3;
    localparam step_t STEP_MOD_DONE = 4'd4;
    localparam step_t STEP_TEST     = 4'd5;
    localparam step_t STEP_HALVE    = 4'd6;
    localparam step_t STEP_SWAP     = 4'd7;
    localparam step_t STEP_EMIT     = 4'd8;
    localparam step_t STEP_WRAP     = 4'd9;

    // Datapath operations of one control word.
    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_MOD_INIT,
        OP_MOD_STEP,
        OP_MOD_DONE,
        OP_HALVE,
        OP_SWAP,
        OP_EMIT
    } op_t;

    // Jump conditions: when true the sequencer goes to the target, else to the next step.
    typedef enum logic [2:0] {
        C_NEXT,
        C_ALWAYS,
        C_NO_REQ,
        C_N_EVEN,
        C_CNT_NZ,
        C_A_ZERO,
        C_A_EVEN,
        C_OUT_BUSY
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } ctrl_t;

    // Microprogram: one control word per step.
    function automatic ctrl_t ucode(input step_t step);
        ctrl_t c;
        begin
            c = '{op: OP_NOP, cond: C_ALWAYS, target: STEP_IDLE};
            unique case (step)
                STEP_IDLE:     c = '{op: OP_LOAD,     cond: C_NO_REQ,   target: STEP_IDLE};
                STEP_CHECK:    c = '{op: OP_NOP,      cond: C_N_EVEN,   target: STEP_EMIT};
                STEP_MOD_INIT: c = '{op: OP_MOD_INIT, cond: C_NEXT,     target: STEP_IDLE};
                STEP_MOD_STEP: c = '{op: OP_MOD_STEP, cond: C_CNT_NZ,   target: STEP_MOD_STEP};
                STEP_MOD_DONE: c = '{op: OP_MOD_DONE, cond: C_NEXT,     target: STEP_IDLE};
                STEP_TEST:     c = '{op: OP_NOP,      cond: C_A_ZERO,   target: STEP_EMIT};
                STEP_HALVE:    c = '{op: OP_HALVE,    cond: C_A_EVEN,   target: STEP_HALVE};
                STEP_SWAP:     c = '{op: OP_SWAP,     cond: C_ALWAYS,   target: STEP_MOD_INIT};
                STEP_EMIT:     c = '{op: OP_EMIT,     cond: C_OUT_BUSY, target: STEP_EMIT};
                STEP_WRAP:     c = '{op: OP_NOP,      cond: C_ALWAYS,   target: STEP_IDLE};
                default:       c = '{op: OP_NOP,      cond: C_ALWAYS,   target: STEP_IDLE};
            endcase
            return c;
        end
    endfunction

endpackage

`default_nettype wire

### src/jac_req_if.sv
`default_nettype none

interface jac_req_if;
    import jac_pkg::*;

    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink (input valid, input value, output ready);
endinterface

`default_nettype wire

### src/jac_rsp_if.sv
`default_nettype none

interface jac_rsp_if;
    import jac_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SYMBOL_W-1:0] symbol;
    logic                       bad_modulus;

    modport source (output valid, output symbol, output bad_modulus, input ready);
    modport sink (input valid, input symbol, input bad_modulus, output ready);
endinterface

`default_nettype wire

### src/jac_cfg_if.sv
`default_nettype none

interface jac_cfg_if;
    import jac_pkg::*;

    logic             valid;
    logic             ready;
    logic [MOD_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### src/jacobi_symbol.sv
// An even modulus goes from the check step straight to the result. Otherwise the value is
// reduced modulo the modulus (one restoring remainder bit per cycle), factors of two are
// removed and reciprocity rounds repeat, at most about two rounds per modulus bit.
// One request at a time: the next is taken only back in the idle step, after the result is
// registered, and a new result waits until the last one has been read.
// Reset: asynchronous, active low; the modulus returns to 3 and no result is pending.
`default_nettype none

`include "assert_macros.svh"

module jacobi_symbol #(
    parameter int unsigned WIDTH = jac_pkg::WIDTH_DEFAULT
) (
    input  wire        clk,
    input  wire        rst_n,
    jac_cfg_if.sink    cfg,
    jac_req_if.sink    req,
    jac_rsp_if.source  rsp
);
    import jac_pkg::*;

    localparam int unsigned CNT_W = $clog2(WIDTH);

    // Sequencer and output control.
    step_t             pc_reg;
    step_t             pc_next;
    ctrl_t             ctrl;
    logic              take_jump;
    logic              req_fire;
    logic              out_busy;
    logic              rsp_valid_reg;
    logic              rsp_valid_next;

    // Configuration.
    logic [WIDTH-1:0]  mod_reg;

    // Datapath.
    logic [WIDTH-1:0]  a_reg;
    logic [WIDTH-1:0]  a_next;
    logic [WIDTH-1:0]  n_reg;
    logic [WIDTH-1:0]  n_next;
    logic [WIDTH-1:0]  rem_reg;
    logic [WIDTH-1:0]  rem_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              neg_reg;
    logic              neg_next;
    logic              bad_reg;
    logic              bad_next;
    logic signed [SYMBOL_W-1:0] sym_reg;
    logic signed [SYMBOL_W-1:0] sym_next;

    // Remainder unit signals.
    logic [WIDTH:0]    shifted;
    logic [WIDTH:0]    diff;
    logic              ge;

    assign ctrl     = ucode(pc_reg);
    assign req_fire = req.valid && req.ready;
    assign out_busy = rsp_valid_reg && !rsp.ready;

    assign cfg.ready       = 1'b1;
    assign req.ready       = (pc_reg == STEP_IDLE);
    assign rsp.valid       = rsp_valid_reg;
    assign rsp.symbol      = sym_reg;
    assign rsp.bad_modulus = bad_reg;

    // Jump condition and next step.
    always_comb
    begin
        take_jump = 1'b0;
        unique case (ctrl.cond)
            C_NEXT:     take_jump = 1'b0;
            C_ALWAYS:   take_jump = 1'b1;
            C_NO_REQ:   take_jump = !req_fire;
            C_N_EVEN:   take_jump = !n_reg[0];
            C_CNT_NZ:   take_jump = (cnt_reg != '0);
            C_A_ZERO:   take_jump = (a_reg == '0);
            C_A_EVEN:   take_jump = !a_reg[0];
            C_OUT_BUSY: take_jump = out_busy;
        endcase
        pc_next = take_jump ? ctrl.target : pc_reg + step_t'(1);
    end

    // One restoring remainder step: shift in the next dividend bit, subtract if it fits.
    always_comb
    begin
        shifted = {rem_reg, a_reg[WIDTH-1]};
        diff    = shifted - {1'b0, n_reg};
        ge      = (shifted >= {1'b0, n_reg});
    end

    // Datapath operations selected by the control word.
    always_comb
    begin
        a_next   = a_reg;
        n_next   = n_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        neg_next = neg_reg;
        bad_next = bad_reg;
        sym_next = sym_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        unique case (ctrl.op)
            OP_NOP:
            begin
            end
            OP_LOAD:
            begin
                if (req_fire)
                begin
                    a_next   = WIDTH'(req.value);
                    n_next   = mod_reg;
                    neg_next = 1'b0;
                end
            end
            OP_MOD_INIT:
            begin
                rem_next = '0;
                cnt_next = CNT_W'(WIDTH - 1);
            end
            OP_MOD_STEP:
            begin
                rem_next = ge ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
                a_next   = a_reg << 1;
                cnt_next = cnt_reg - CNT_W'(1);
            end
            OP_MOD_DONE:
            begin
                a_next = rem_reg;
            end
            OP_HALVE:
            begin
                // Each factor of two flips the sign when the modulus is 3 or 5 mod 8.
                if (!a_reg[0])
                begin
                    a_next = a_reg >> 1;
                    if (n_reg[2:0] == 3'd3 || n_reg[2:0] == 3'd5)
                    begin
                        neg_next = !neg_reg;
                    end
                end
            end
            OP_SWAP:
            begin
                // Reciprocity: flip when both operands are 3 mod 4.
                a_next = n_reg;
                n_next = a_reg;
                if (a_reg[1:0] == 2'd3 && n_reg[1:0] == 2'd3)
                begin
                    neg_next = !neg_reg;
                end
            end
            OP_EMIT:
            begin
                if (!out_busy)
                begin
                    rsp_valid_next = 1'b1;
                    bad_next       = !n_reg[0];
                    if (!n_reg[0] || n_reg != WIDTH'(1))
                    begin
                        sym_next = SYM_ZERO;
                    end
                    else
                    begin
                        sym_next = neg_reg ? SYM_NEG : SYM_POS;
                    end
                end
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= STEP_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Modulus register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mod_reg <= WIDTH'(MODULUS_RESET);
        end
        else if (cfg.valid && cfg.ready)
        begin
            mod_reg <= WIDTH'(cfg.data);
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        n_reg   <= n_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
        neg_reg <= neg_next;
        bad_reg <= bad_next;
        sym_reg <= sym_next;
    end

    // A taken request always moves the sequencer on to the modulus check.
    `ASSERT_PROP(a_req_starts, clk, rst_n, req_fire |=> (pc_reg == STEP_CHECK),
        "accepted request did not start the program")
    // The remainder loop only ever runs against an odd, nonzero modulus.
    `ASSERT_ALWAYS(a_mod_odd, clk, rst_n,
        (pc_reg != STEP_MOD_STEP) || (n_reg[0] && n_reg != '0),
        "remainder step with an even divisor")
    // The partial remainder stays below the divisor.
    `ASSERT_ALWAYS(a_rem_bound, clk, rst_n, (pc_reg != STEP_MOD_STEP) || (rem_reg < n_reg),
        "partial remainder out of range")
    // A result waiting at the output holds the sequencer at the emit step.
    `ASSERT_PROP(a_emit_hold, clk, rst_n, (pc_reg == STEP_EMIT && out_busy) |=>
        (pc_reg == STEP_EMIT), "result emitted over a pending one")
    // The symbol code is legal and zero whenever the modulus is flagged.
    `ASSERT_ALWAYS(a_sym_legal, clk, rst_n,
        !rsp_valid_reg || (sym_reg != 2'sb10 && (!bad_reg || sym_reg == SYM_ZERO)),
        "illegal symbol code at the output")

endmodule

`default_nettype wire

### test/tb_jacobi_symbol.sv
`timescale 1ns / 100ps

module tb_jacobi_symbol;
    import jac_pkg::*;

    localparam int RANDOM_ITEMS  = 700;
    localparam int WATCHDOG_MAX  = 20000;
    localparam int LONG_HOLD     = 800;
    localparam int DRAIN_CYCLES  = 400;
    localparam int DIR_COUNT     = 25;

    // Symbol and error flag of one result.
    typedef struct packed {
        logic signed [SYMBOL_W-1:0] symbol;
        logic                       bad_modulus;
    } jac_result_t;

    // One request still waiting for its result.
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [MOD_W-1:0]   modulus;
        jac_result_t        result;
    } pending_sym_t;

    // One row of the directed table: an optional modulus write, then one request.
    typedef struct packed {
        logic                       set_mod;
        logic [MOD_W-1:0]           modulus;
        logic [VALUE_W-1:0]         value;
        logic                       typed;
        logic signed [SYMBOL_W-1:0] symbol;
        logic                       bad_modulus;
    } dir_row_t;

    localparam dir_row_t DIR_ROWS [DIR_COUNT] = '{
        '{1'b0, 32'd3,          32'd0,          1'b1, SYM_ZERO, 1'b0},
        '{1'b0, 32'd3,          32'd1,          1'b1, SYM_POS,  1'b0},
        '{1'b0, 32'd3,          32'd2,          1'b1, SYM_NEG,  1'b0},
        '{1'b0, 32'd3,          32'd3,          1'b1, SYM_ZERO, 1'b0},
        '{1'b0, 32'd3,          32'hFFFFFFFF,   1'b0, SYM_ZERO, 1'b0},
        '{1'b1, 32'd1,          32'd0,          1'b1, SYM_POS,  1'b0},
        '{1'b0, 32'd1,          32'hFFFFFFFF,   1'b1, SYM_POS,  1'b0},
        '{1'b1, 32'd0,          32'd5,          1'b1, SYM_ZERO, 1'b1},
        '{1'b1, 32'd2,          32'hFFFFFFFF,   1'b1, SYM_ZERO, 1'b1},
        '{1'b1, 32'hFFFFFFFE,   32'd1,          1'b1, SYM_ZERO, 1'b1},
        '{1'b1, 32'hFFFFFFFF,   32'd0,          1'b1, SYM_ZERO, 1'b0},
        '{1'b0, 32'hFFFFFFFF,   32'd1,          1'b1, SYM_POS,  1'b0},
        '{1'b0, 32'hFFFFFFFF,   32'hFFFFFFFF,   1'b1, SYM_ZERO, 1'b0},
        '{1'b0, 32'hFFFFFFFF,   32'hFFFFFFFE,   1'b0, SYM_ZERO, 1'b0},
        '{1'b0, 32'hFFFFFFFF,   32'd2,          1'b0, SYM_ZERO, 1'b0},
        '{1'b1, 32'hFFFFFFFB,   32'd2,          1'b0, SYM_ZERO, 1'b0},
        '{1'b0, 32'hFFFFFFFB,   32'h80000000,   1'b0, SYM_ZERO, 1'b0},
        '{1'b0, 32'hFFFFFFFB,   32'h55555555,   1'b0, SYM_ZERO, 1'b0},
        '{1'b0, 32'hFFFFFFFB,   32'hAAAAAAAA,   1'b0, SYM_ZERO, 1'b0},
        '{1'b1, 32'd7,          32'd3,          1'b0, SYM_ZERO, 1'b0},
        '{1'b0, 32'd7,          32'd5,          1'b0, SYM_ZERO, 1'b0},
        '{1'b0, 32'd7,          32'd14,         1'b0, SYM_ZERO, 1'b0},
        '{1'b1, 32'd15,         32'd5,          1'b1, SYM_ZERO, 1'b0},
        '{1'b0, 32'd15,         32'd2,          1'b0, SYM_ZERO, 1'b0},
        '{1'b0, 32'd15,         32'hFFFFFFF0,   1'b0, SYM_ZERO, 1'b0}
    };

    logic clk = 1'b0;
    logic rst_n;

    jac_cfg_if cfg_bus ();
    jac_req_if req_bus ();
    jac_rsp_if rsp_bus ();

    jacobi_symbol dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_bus),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    // Shadow of the modulus register and the symbols still owed by the block.
    logic [MOD_W-1:0] modulus_q = MODULUS_RESET;
    pending_sym_t     pending_syms [$];

    int  errors        = 0;
    int  results_seen  = 0;
    int  requests_sent = 0;
    int  modulus_loads = 0;
    int  holds_done    = 0;
    int  n_residue     = 0;
    int  n_nonresidue  = 0;
    int  n_common      = 0;
    int  n_even_mod    = 0;
    int  quiet_cycles  = 0;
    bit  smooth_run    = 1'b0;
    bit  sink_hold_req = 1'b0;

    always #5 clk = ~clk;

    // Every input is known from the very start.
    initial
    begin
        rst_n         <= 1'b0;
        req_bus.valid <= 1'b0;
        req_bus.value <= '0;
        cfg_bus.valid <= 1'b0;
        cfg_bus.data  <= '0;
        rsp_bus.ready <= 1'b0;
    end

    task automatic report_error(input string msg);
        errors++;
        $display("ERROR at %0t: %s", $time, msg);
    endtask

    // Jacobi symbol of a value over the modulus, by the binary reciprocity loop.
    function automatic jac_result_t predict_symbol(input logic [VALUE_W-1:0] v_in,
                                                   input logic [MOD_W-1:0] m_in);
        jac_result_t res;
        logic [63:0] a;
        logic [63:0] n;
        logic [63:0] t;
        bit          flip;
        res.symbol      = SYM_ZERO;
        res.bad_modulus = 1'b0;
        if (!m_in[0])
        begin
            res.bad_modulus = 1'b1;
            return res;
        end
        flip = 1'b0;
        n = 64'(m_in);
        a = 64'(v_in) % n;
        while (a != 0)
        begin
            // Strip factors of two; the sign flips when n is 3 or 5 mod 8.
            while (!a[0])
            begin
                a = a >> 1;
                if (n[2:0] == 3'd3 || n[2:0] == 3'd5)
                    flip = ~flip;
            end
            // Reciprocity: swap, flip when both are 3 mod 4, then reduce.
            t = a;
            a = n;
            n = t;
            if (a[1:0] == 2'd3 && n[1:0] == 2'd3)
                flip = ~flip;
            a = a % n;
        end
        if (n == 1)
            res.symbol = flip ? SYM_NEG : SYM_POS;
        return res;
    endfunction

    function automatic int pick_gap(input bit smooth);
        int r;
        r = $urandom_range(0, 99);
        if (smooth || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 60);
    endfunction

    function automatic logic [MOD_W-1:0] pick_modulus();
        logic [MOD_W-1:0] m;
        logic [MOD_W-1:0] primes [6];
        primes = '{32'hFFFFFFFB, 32'h7FFFFFFF, 32'd65521, 32'd251, 32'd7, 32'd97};
        m = $urandom;
        case ($urandom_range(0, 11))
            0: m = MOD_W'($urandom_range(0, 255)) | 1;
            1: m = 32'd15015;
            2: m = '1;
            3: m[0] = 1'b0;
            4: m = primes[$urandom_range(0, 5)];
            5: m = 32'h80000001;
            default: m[0] = 1'b1;
        endcase
        return m;
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value(input logic [MOD_W-1:0] m);
        logic [VALUE_W-1:0] v;
        v = $urandom;
        case ($urandom_range(0, 9))
            0: v = '0;
            1: v = '1;
            2: v = VALUE_W'($urandom_range(0, 64));
            3: v = m * VALUE_W'($urandom_range(1, 5));
            4: v = VALUE_W'(1) << $urandom_range(0, VALUE_W - 1);
            5: v = m - 1;
            default: ;
        endcase
        return v;
    endfunction

    // Offers one request after an optional gap and records its expected symbol.
    task automatic send_value(input logic [VALUE_W-1:0] v, input bit typed,
                              input jac_result_t typed_res);
        int          gap;
        pending_sym_t ent;
        gap = pick_gap(smooth_run);
        if (gap > 0)
        begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_bus.valid <= 1'b1;
        req_bus.value <= v;
        do
            @(posedge clk);
        while (!(req_bus.valid && req_bus.ready));
        ent.value   = v;
        ent.modulus = modulus_q;
        ent.result  = typed ? typed_res : predict_symbol(v, modulus_q);
        pending_syms.push_back(ent);
        requests_sent++;
    endtask

    // Writes the modulus once every owed result has come back.
    task automatic load_modulus(input logic [MOD_W-1:0] m);
        req_bus.valid <= 1'b0;
        while (pending_syms.size() > 0)
            @(posedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.data  <= m;
        do
            @(posedge clk);
        while (!(cfg_bus.valid && cfg_bus.ready));
        cfg_bus.valid <= 1'b0;
        modulus_q = m;
        modulus_loads++;
    endtask

    // Result sink: random back-pressure plus one long hold on request.
    initial
    begin : sink_drive
        int idle_left;
        int r;
        idle_left = 0;
        forever
        begin
            @(posedge clk);
            if (sink_hold_req)
            begin
                sink_hold_req = 1'b0;
                idle_left = LONG_HOLD;
                holds_done++;
            end
            if (idle_left > 0)
            begin
                rsp_bus.ready <= 1'b0;
                idle_left--;
            end
            else
            begin
                rsp_bus.ready <= 1'b1;
                if (!smooth_run)
                begin
                    r = $urandom_range(0, 99);
                    if (r >= 60)
                        idle_left = (r < 92) ? $urandom_range(1, 4) : $urandom_range(10, 80);
                end
            end
        end
    end

    // Compare each returned symbol with the oldest one owed.
    always @(posedge clk)
    begin : symbol_check
        pending_sym_t want;
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            results_seen++;
            if (rsp_bus.bad_modulus)
                n_even_mod++;
            else if (rsp_bus.symbol == SYM_POS)
                n_residue++;
            else if (rsp_bus.symbol == SYM_NEG)
                n_nonresidue++;
            else
                n_common++;
            if (pending_syms.size() == 0)
            begin
                report_error("result returned with no request outstanding");
            end
            else
            begin
                want = pending_syms.pop_front();
                if (rsp_bus.symbol !== want.result.symbol)
                    report_error($sformatf("value %h mod %h: symbol %0d, expected %0d",
                        want.value, want.modulus, $signed(rsp_bus.symbol),
                        $signed(want.result.symbol)));
                if (rsp_bus.bad_modulus !== want.result.bad_modulus)
                    report_error($sformatf("value %h mod %h: bad_modulus %b, expected %b",
                        want.value, want.modulus, rsp_bus.bad_modulus,
                        want.result.bad_modulus));
            end
        end
    end

    // Watchdog: too long without any handshake ends the run.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
                (cfg_bus.valid && cfg_bus.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_MAX)
            begin
                $display("Watchdog expired after %0d idle cycles, %0d results owed",
                         quiet_cycles, pending_syms.size());
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int               phase;
        int               phase_len;
        int               random_sent;
        logic [MOD_W-1:0] m;
        jac_result_t      typed_res;
        jac_result_t      none;
        none = '{symbol: SYM_ZERO, bad_modulus: 1'b0};
        random_sent = 0;
        phase = 0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: extremes, even moduli, modulus one, value zero.
        for (int i = 0; i < DIR_COUNT; i++)
        begin
            if (DIR_ROWS[i].set_mod)
                load_modulus(DIR_ROWS[i].modulus);
            typed_res.symbol      = DIR_ROWS[i].symbol;
            typed_res.bad_modulus = DIR_ROWS[i].bad_modulus;
            send_value(DIR_ROWS[i].value, DIR_ROWS[i].typed, typed_res);
        end

        // Random phases, each with its own modulus.
        while (random_sent < RANDOM_ITEMS)
        begin
            m = (phase == 1) ? MOD_W'(7) : pick_modulus();
            load_modulus(m);
            phase_len = m[0] ? $urandom_range(15, 60) : $urandom_range(3, 8);
            smooth_run = ($urandom_range(0, 3) == 0);
            if (phase == 1)
            begin
                // Stall the sink for a long stretch while requests keep coming.
                smooth_run = 1'b1;
                sink_hold_req = 1'b1;
                phase_len = 30;
            end
            for (int k = 0; k < phase_len; k++)
            begin
                send_value(pick_value(m), 1'b0, none);
                random_sent++;
            end
            phase++;
        end

        // Let every owed result come back, then watch for strays.
        req_bus.valid <= 1'b0;
        smooth_run = 1'b0;
        while (pending_syms.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d requests over %0d modulus loads, %0d long sink hold(s).",
                 requests_sent, modulus_loads, holds_done);
        $display("Results: %0d residues, %0d non-residues, %0d common factors, %0d even moduli.",
                 n_residue, n_nonresidue, n_common, n_even_mod);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
